// File: rtl/dhaf_pkg.sv
// ----------------------------------------------------------------------------
// dhaf_pkg
// shared types and constants for the diameter header and avp framer
// ----------------------------------------------------------------------------
package dhaf_pkg;

  localparam int BYTE_W    = 8;
  localparam int POS_W     = 25;
  localparam int LEN_W     = 24;
  localparam int START_W   = 26;
  localparam int CMP_W     = START_W + 1;
  localparam int HDR_BYTES = 20;
  localparam int HDR_W     = HDR_BYTES * BYTE_W;
  localparam int AVP_HDR_BASE = 8;
  localparam int AVP_HDR_VEND = 12;
  localparam int AVP_WORDS = 3;

  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
  localparam logic [7:0]       DIAM_VERSION = 8'd1;

  typedef enum logic [1:0] {
    KIND_HDR    = 2'd0,
    KIND_AVP    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_VERSION     = 3'd2,
    ST_MSGLEN      = 3'd3,
    ST_INCOMPLETE  = 3'd4,
    ST_AVP_TRUNC   = 3'd5,
    ST_AVP_SMALL   = 3'd6,
    ST_AVP_OVERRUN = 3'd7
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] code;
    logic [7:0]  flags;
    logic [23:0] len;
    logic [31:0] ida;
    logic [31:0] hop;
    logic [31:0] endi;
    status_t     st;
    logic        last;
  } rec_t;

  // records produced by one accepted byte, rec0 first
  typedef struct packed {
    logic [1:0] n;
    rec_t       rec0;
    rec_t       rec1;
  } step_t;

endpackage

// File: rtl/dhaf_in_if.sv
// ----------------------------------------------------------------------------
// dhaf_in_if
// byte channel into the framer
// ----------------------------------------------------------------------------
interface dhaf_in_if;
  import dhaf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

// File: rtl/dhaf_out_if.sv
// ----------------------------------------------------------------------------
// dhaf_out_if
// record channel out of the framer
// ----------------------------------------------------------------------------
interface dhaf_out_if;
  import dhaf_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [31:0] code;
  logic [7:0]  flag_bits;
  logic [23:0] length_value;
  logic [31:0] ident_a;
  logic [31:0] hop_ident;
  logic [31:0] end_ident;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, record_kind, code, flag_bits, length_value, ident_a,
                  hop_ident, end_ident, status, last, input ready);
  modport sink   (input valid, record_kind, code, flag_bits, length_value, ident_a,
                  hop_ident, end_ident, status, last, output ready);
endinterface

// File: rtl/dhaf_parser.sv
// ----------------------------------------------------------------------------
// dhaf_parser
// per-byte header capture, avp walk and end-of-buffer status
// ----------------------------------------------------------------------------
module dhaf_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_buffer,
  output dhaf_pkg::step_t       step
);
  import dhaf_pkg::*;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [HDR_W-1:0]   hdr_r, hdr_nxt, hdr_full;
  logic [LEN_W-1:0]   mlen_r, mlen_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [31:0]        avp_w_r [AVP_WORDS];
  logic [31:0]        avp_w_nxt [AVP_WORDS];
  logic [31:0]        w_upd [AVP_WORDS];
  logic               vend_hdr_r, vend_hdr_nxt;
  status_t            ferr_r, ferr_nxt;
  logic               active_r, active_nxt;

  logic [7:0]         hdr_ver;
  logic [LEN_W-1:0]   hdr_ml;
  logic               in_hdr, hdr_done, in_avp;
  logic [START_W-1:0] idx;
  logic [LEN_W-1:0]   alen;
  logic               vflag;
  logic [1:0]         pad;
  logic [CMP_W-1:0]   start_x, mlen_x, alen_x;
  logic               trunc_vend, overrun;
  logic [START_W-1:0] next_start;
  logic               finish;
  logic               have_main, begin_go;
  logic [START_W-1:0] begin_start;
  rec_t               rec_main, rec_stat;
  status_t            st;
  logic               short_buf, incomplete;

  // header bytes, first byte at the top
  assign hdr_full = {hdr_r[HDR_W-BYTE_W-1:0], data_byte};
  assign hdr_ver  = hdr_full[HDR_W-1 -: 8];
  assign hdr_ml   = hdr_full[HDR_W-9 -: LEN_W];

  assign in_hdr   = pos_r < POS_W'(HDR_BYTES);
  assign hdr_done = pos_r == POS_W'(HDR_BYTES - 1);
  assign in_avp   = !in_hdr && (ferr_r == ST_OK) && active_r &&
                    ({1'b0, pos_r} >= start_r) && (pos_r < POS_W'(mlen_r));
  assign idx      = {1'b0, pos_r} - start_r;

  // each avp header word takes its four bytes in order
  always_comb begin
    for (int i = 0; i < AVP_WORDS; i++) begin
      if (in_avp && (idx < START_W'(AVP_HDR_VEND)) && (idx[3:2] == 2'(i)))
        w_upd[i] = {avp_w_r[i][23:0], data_byte};
      else
        w_upd[i] = avp_w_r[i];
    end
  end

  assign alen       = w_upd[1][LEN_W-1:0];
  assign vflag      = w_upd[1][31];
  assign pad        = 2'(2'd0 - alen[1:0]);
  assign start_x    = {1'b0, start_r};
  assign mlen_x     = CMP_W'(mlen_r);
  assign alen_x     = CMP_W'(alen);
  assign trunc_vend = (start_x + CMP_W'(AVP_HDR_VEND)) > mlen_x;
  assign overrun    = (start_x + alen_x) > mlen_x;
  assign next_start = START_W'(start_x + alen_x + CMP_W'(pad));

  always_comb begin
    pos_nxt      = pos_r;
    hdr_nxt      = hdr_r;
    mlen_nxt     = mlen_r;
    start_nxt    = start_r;
    avp_w_nxt    = avp_w_r;
    vend_hdr_nxt = vend_hdr_r;
    ferr_nxt     = ferr_r;
    active_nxt   = active_r;
    rec_main     = '0;
    have_main    = 1'b0;
    begin_go     = 1'b0;
    begin_start  = start_r;
    finish       = 1'b0;

    if (in_hdr) begin
      hdr_nxt = hdr_full;
      if (hdr_done) begin
        if (hdr_ver != DIAM_VERSION) begin
          ferr_nxt = ST_VERSION;
        end else if (hdr_ml < LEN_W'(HDR_BYTES)) begin
          ferr_nxt = ST_MSGLEN;
        end else begin
          mlen_nxt       = hdr_ml;
          rec_main.kind  = KIND_HDR;
          rec_main.code  = 32'(hdr_full[119:96]);
          rec_main.flags = hdr_full[127:120];
          rec_main.len   = hdr_ml;
          rec_main.ida   = hdr_full[95:64];
          rec_main.hop   = hdr_full[63:32];
          rec_main.endi  = hdr_full[31:0];
          have_main      = 1'b1;
          begin_go       = 1'b1;
          begin_start    = START_W'(HDR_BYTES);
        end
      end
    end else if (in_avp) begin
      avp_w_nxt = w_upd;
      if (idx == START_W'(AVP_HDR_BASE - 1)) begin
        if (alen < LEN_W'(AVP_HDR_BASE)) begin
          ferr_nxt   = ST_AVP_SMALL;
          active_nxt = 1'b0;
        end else if (vflag) begin
          if (trunc_vend) begin
            ferr_nxt   = ST_AVP_TRUNC;
            active_nxt = 1'b0;
          end else begin
            vend_hdr_nxt = 1'b1;
          end
        end else begin
          finish = 1'b1;
        end
      end else if ((idx == START_W'(AVP_HDR_VEND - 1)) && vend_hdr_r) begin
        if (alen < LEN_W'(AVP_HDR_VEND)) begin
          ferr_nxt   = ST_AVP_SMALL;
          active_nxt = 1'b0;
        end else begin
          finish = 1'b1;
        end
      end
      if (finish) begin
        if (overrun) begin
          ferr_nxt   = ST_AVP_OVERRUN;
          active_nxt = 1'b0;
        end else begin
          rec_main.kind  = KIND_AVP;
          rec_main.code  = w_upd[0];
          rec_main.flags = w_upd[1][31:24];
          rec_main.len   = alen;
          rec_main.ida   = vflag ? w_upd[2] : 32'd0;
          have_main      = 1'b1;
          begin_go       = 1'b1;
          begin_start    = next_start;
        end
      end
    end

    // open the next avp, or end the walk at the message length, flagging an avp header cut by it
    if (begin_go) begin
      for (int i = 0; i < AVP_WORDS; i++) avp_w_nxt[i] = '0;
      vend_hdr_nxt = 1'b0;
      start_nxt    = begin_start;
      if ({1'b0, begin_start} >= CMP_W'(mlen_nxt)) begin
        active_nxt = 1'b0;
      end else if (({1'b0, begin_start} + CMP_W'(AVP_HDR_BASE)) > CMP_W'(mlen_nxt)) begin
        active_nxt = 1'b0;
        ferr_nxt   = ST_AVP_TRUNC;
      end else begin
        active_nxt = 1'b1;
      end
    end

    if (pos_r != POS_MAX) pos_nxt = pos_r + POS_W'(1);

    // final status ranking
    short_buf  = pos_r < POS_W'(HDR_BYTES - 1);
    incomplete = ({1'b0, pos_r} + START_W'(1)) < START_W'(mlen_nxt);
    if (short_buf) st = ST_SHORT;
    else if (ferr_nxt == ST_VERSION || ferr_nxt == ST_MSGLEN) st = ferr_nxt;
    else if (incomplete) st = ST_INCOMPLETE;
    else st = ferr_nxt;

    rec_stat      = '0;
    rec_stat.kind = KIND_STATUS;
    rec_stat.st   = st;
    rec_stat.last = 1'b1;

    if (end_of_buffer) begin
      pos_nxt      = '0;
      mlen_nxt     = '0;
      start_nxt    = START_W'(HDR_BYTES);
      vend_hdr_nxt = 1'b0;
      ferr_nxt     = ST_OK;
      active_nxt   = 1'b0;
    end
  end

  assign step.n    = take ? ({1'b0, have_main} + {1'b0, end_of_buffer}) : 2'd0;
  assign step.rec0 = have_main ? rec_main : rec_stat;
  assign step.rec1 = rec_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      mlen_r     <= '0;
      start_r    <= START_W'(HDR_BYTES);
      vend_hdr_r <= 1'b0;
      ferr_r     <= ST_OK;
      active_r   <= 1'b0;
    end else if (take) begin
      pos_r      <= pos_nxt;
      mlen_r     <= mlen_nxt;
      start_r    <= start_nxt;
      vend_hdr_r <= vend_hdr_nxt;
      ferr_r     <= ferr_nxt;
      active_r   <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hdr_r   <= hdr_nxt;
      avp_w_r <= avp_w_nxt;
    end
  end

  a_active_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ferr_r == ST_OK)
    else $error("avp walk active after an error");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    ferr_r != ST_SHORT && ferr_r != ST_INCOMPLETE)
    else $error("stored error holds a status-only code");

  a_eob_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && end_of_buffer |=> pos_r == '0 && !active_r && ferr_r == ST_OK)
    else $error("state not cleared after last byte");
endmodule

// File: rtl/dhaf_out_fifo.sv
// ----------------------------------------------------------------------------
// dhaf_out_fifo
// record queue, up to two pushes and one pop a cycle
// ----------------------------------------------------------------------------
module dhaf_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dhaf_pkg::step_t   step,
  output logic              room,
  dhaf_out_if.source        out_ch
);
  import dhaf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             mem_r [DEPTH];
  rec_t             head;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr1;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_ptr1 = ptr_inc(wr_ptr_r);
  assign pop     = out_ch.valid && out_ch.ready;
  assign room    = cnt_r <= CNT_W'(DEPTH - 2);

  always_comb begin
    case (step.n)
      2'd1:    wr_ptr_nxt = wr_ptr1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(step.n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.n != 2'd0) mem_r[wr_ptr_r] <= step.rec0;
    if (step.n == 2'd2) mem_r[wr_ptr1]  <= step.rec1;
  end

  assign head                = mem_r[rd_ptr_r];
  assign out_ch.valid        = cnt_r != '0;
  assign out_ch.record_kind  = head.kind;
  assign out_ch.code         = head.code;
  assign out_ch.flag_bits    = head.flags;
  assign out_ch.length_value = head.len;
  assign out_ch.ident_a      = head.ida;
  assign out_ch.hop_ident    = head.hop;
  assign out_ch.end_ident    = head.endi;
  assign out_ch.status       = head.st;
  assign out_ch.last         = head.last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("record queue count past depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    step.n != 2'd0 |-> cnt_r <= CNT_W'(DEPTH - 2))
    else $error("records pushed without room for two");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last |-> out_ch.record_kind == KIND_STATUS)
    else $error("last flag on a non-status record");
endmodule

// File: rtl/diameter_header_avp_framer_top.sv
// ----------------------------------------------------------------------------
// diameter_header_avp_framer_top
// byte-serial diameter header check and avp header walk
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one buffer byte per item with end_of_buffer on the last one.
//   out_ch carries records: one message header record once byte 20 is in and
//   the header is sound, one record per good avp header, and a status record
//   with last set after the final byte of every buffer.
//   a byte is taken every cycle while ready is high; all work for a byte is
//   done in the cycle it is accepted, and its records are written into the
//   output queue as the byte is taken (throughput 1 byte/cycle while ready is high).
//   records go into a small queue; ready drops while fewer than two free
//   entries remain, so a receiver that stalls back-pressures the byte stream
//   and nothing is lost. the last byte of a buffer can give two records.
//   synchronous reset empties the queue and returns the parser to the start
//   of a buffer; the parser alone also does this internally after every last byte.
// ----------------------------------------------------------------------------
module diameter_header_avp_framer_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  dhaf_in_if.sink     in_ch,
  dhaf_out_if.source  out_ch
);
  import dhaf_pkg::*;

  logic  take;
  logic  room;
  step_t step;

  // byte accepted this cycle
  assign in_ch.ready = room;
  assign take        = in_ch.valid && room;

  // header capture, avp walk, status ranking
  dhaf_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .data_byte     (in_ch.data_byte),
    .end_of_buffer (in_ch.end_of_buffer),
    .step          (step)
  );

  // record queue in front of the output handshake
  dhaf_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .room   (room),
    .out_ch (out_ch)
  );
endmodule

// File: tb/tb_diameter_header_avp_framer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_diameter_header_avp_framer_top
// self-checking bench for the byte-serial diameter header and avp framer
// ----------------------------------------------------------------------------
// a plan of buffer bytes is built up front: a directed set of buffers for the
// header checks, the avp walk and the status ranking, then random messages,
// most well formed with random content, some broken, some plain noise. a
// clocked driver feeds the plan with random idle bursts, a clocked monitor
// runs every accepted byte through a local framer model and compares each
// record leaving the block against the oldest predicted record.
// ----------------------------------------------------------------------------
module tb_diameter_header_avp_framer_top;
  import dhaf_pkg::*;

  localparam int RANDOM_BYTES = 600;   // size of the random part of the plan
  localparam int CALM_BYTES   = 150;   // no idling once this few bytes remain
  localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
  localparam int TAIL_CYCLES  = 10;    // settle time after the last record
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [7:0] data;
    logic       eob;
    bit         hold;  // wait for every pending record before this byte
  } plan_item_t;

  logic clk;
  logic rst_n;

  dhaf_in_if  in_ch ();
  dhaf_out_if out_ch ();

  diameter_header_avp_framer_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // stimulus plan and predicted records
  plan_item_t  byte_plan[$];
  logic [7:0]  msg_bytes[$];
  rec_t        want_records[$];

  // bookkeeping
  int unsigned total_bytes  = 0;
  int unsigned bytes_taken  = 0;
  int unsigned errors       = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_hdr = 0, n_avp = 0, n_stat = 0, n_buffers = 0;
  int unsigned status_seen[8];
  bit          in_fire = 0;  // byte accepted at the last rising edge

  // idle burst state for each side
  int unsigned src_gap = 0, src_quiet = 0;
  int unsigned snk_gap = 0, snk_quiet = 0;

  // --------------------------------------------------------------------------
  // framer model state
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] rx_pos;
  logic [HDR_W-1:0] hdr_win;     // first 20 bytes, oldest byte on top
  int unsigned      msg_len;
  int unsigned      avp_at;      // byte offset of the avp being walked
  logic [31:0]      avp_word[AVP_WORDS];
  int unsigned      avp_hlen;
  status_t          first_err;
  bit               avp_open;

  task automatic reset_model();
    rx_pos    = '0;
    hdr_win   = '0;
    msg_len   = 0;
    avp_at    = HDR_BYTES;
    avp_word  = '{default: '0};
    avp_hlen  = AVP_HDR_BASE;
    first_err = ST_OK;
    avp_open  = 1'b0;
  endtask

  // set up the walk for an avp starting at byte offset start
  task automatic open_avp(input int unsigned start);
    avp_word = '{default: '0};
    avp_hlen = AVP_HDR_BASE;
    avp_at   = start;
    if (start >= msg_len) begin
      // walk done, padding may well carry past the end
      avp_open = 1'b0;
    end else if (start + AVP_HDR_BASE > msg_len) begin
      avp_open  = 1'b0;
      first_err = ST_AVP_TRUNC;
    end else begin
      avp_open = 1'b1;
    end
  endtask

  // advance the model by one accepted byte and queue the records it causes
  task automatic frame_byte(input logic [7:0] b, input logic eob);
    int unsigned p, idx, alen, pad, cnt;
    logic        vflag, finish;
    rec_t        r;
    status_t     st;
    p      = rx_pos;
    finish = 1'b0;
    if (p < HDR_BYTES) begin
      hdr_win = {hdr_win[HDR_W-9:0], b};
      if (p == HDR_BYTES - 1) begin
        if (hdr_win[159:152] != DIAM_VERSION) begin
          first_err = ST_VERSION;
        end else if (hdr_win[151:128] < HDR_BYTES) begin
          first_err = ST_MSGLEN;
        end else begin
          msg_len = hdr_win[151:128];
          r       = '0;
          r.kind  = KIND_HDR;
          r.code  = {8'h00, hdr_win[119:96]};
          r.flags = hdr_win[127:120];
          r.len   = hdr_win[151:128];
          r.ida   = hdr_win[95:64];
          r.hop   = hdr_win[63:32];
          r.endi  = hdr_win[31:0];
          r.st    = ST_OK;
          want_records = {want_records, r};
          open_avp(HDR_BYTES);
        end
      end
    end else if (first_err == ST_OK && avp_open && p >= avp_at && p < msg_len) begin
      idx = p - avp_at;
      if (idx < AVP_HDR_VEND) begin
        avp_word[idx / 4] = {avp_word[idx / 4][23:0], b};
      end
      alen  = avp_word[1][23:0];
      vflag = avp_word[1][31];
      if (idx == AVP_HDR_BASE - 1) begin
        if (alen < AVP_HDR_BASE) begin
          first_err = ST_AVP_SMALL;
          avp_open  = 1'b0;
        end else if (vflag) begin
          // length check first, then does the vendor id still fit
          if (avp_at + AVP_HDR_VEND > msg_len) begin
            first_err = ST_AVP_TRUNC;
            avp_open  = 1'b0;
          end else begin
            avp_hlen = AVP_HDR_VEND;
          end
        end else begin
          finish = 1'b1;
        end
      end else if (idx == AVP_HDR_VEND - 1 && avp_hlen == AVP_HDR_VEND) begin
        if (alen < AVP_HDR_VEND) begin
          first_err = ST_AVP_SMALL;
          avp_open  = 1'b0;
        end else begin
          finish = 1'b1;
        end
      end
      if (finish) begin
        if (avp_at + alen > msg_len) begin
          first_err = ST_AVP_OVERRUN;
          avp_open  = 1'b0;
        end else begin
          pad     = (4 - (alen & 3)) & 3;
          r       = '0;
          r.kind  = KIND_AVP;
          r.code  = avp_word[0];
          r.flags = avp_word[1][31:24];
          r.len   = alen;
          r.ida   = vflag ? avp_word[2] : 32'h0;
          r.st    = ST_OK;
          want_records = {want_records, r};
          open_avp(avp_at + alen + pad);
        end
      end
    end
    if (rx_pos != POS_MAX) rx_pos = rx_pos + 1'b1;
    if (eob) begin
      // ranking: short, header errors, incomplete, then the first avp error
      cnt = p + 1;
      if (cnt < HDR_BYTES) begin
        st = ST_SHORT;
      end else if (first_err == ST_VERSION || first_err == ST_MSGLEN) begin
        st = first_err;
      end else if (cnt < msg_len) begin
        st = ST_INCOMPLETE;
      end else begin
        st = first_err;
      end
      r      = '0;
      r.kind = KIND_STATUS;
      r.st   = st;
      r.last = 1'b1;
      want_records = {want_records, r};
      reset_model();
    end
  endtask

  // --------------------------------------------------------------------------
  // buffer builders, all big endian like the wire format
  // --------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] v);
    msg_bytes = {msg_bytes, v};
  endtask

  task automatic put_word(input logic [31:0] v, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endtask

  task automatic put_header(input logic [7:0] ver, input logic [7:0] flags,
                            input logic [23:0] ml, input logic [23:0] cmd,
                            input logic [31:0] app, input logic [31:0] hop,
                            input logic [31:0] e2e);
    add_byte(ver);
    put_word(ml, 3);
    add_byte(flags);
    put_word(cmd, 3);
    put_word(app, 4);
    put_word(hop, 4);
    put_word(e2e, 4);
  endtask

  // avp header (vendor id only with flag 0x80), dlen data bytes, optional pad
  task automatic put_avp(input logic [31:0] code, input logic [7:0] flags,
                         input logic [23:0] alen, input logic [31:0] vend,
                         input int dlen, input bit padded);
    int hlen, pad;
    hlen = flags[7] ? AVP_HDR_VEND : AVP_HDR_BASE;
    put_word(code, 4);
    add_byte(flags);
    put_word(alen, 3);
    if (flags[7]) put_word(vend, 4);
    repeat (dlen) add_byte($urandom);
    pad = padded ? (4 - ((hlen + dlen) % 4)) % 4 : 0;
    repeat (pad) add_byte($urandom);
  endtask

  task automatic set_len(input logic [23:0] v);
    msg_bytes[1] = v[23:16];
    msg_bytes[2] = v[15:8];
    msg_bytes[3] = v[7:0];
  endtask

  task automatic fix_len();
    set_len(msg_bytes.size());
  endtask

  // move the current buffer into the plan, end flag on its last byte
  task automatic send_msg(input bit hold);
    int i;
    plan_item_t it;
    for (i = 0; i < msg_bytes.size(); i++) begin
      it.data = msg_bytes[i];
      it.eob  = (i == msg_bytes.size() - 1);
      it.hold = hold && (i == 0);
      byte_plan = {byte_plan, it};
    end
    msg_bytes.delete();
  endtask

  function automatic string rec_text(input rec_t r);
    return $sformatf("kind=%0d code=%h flags=%h len=%h ida=%h hop=%h end=%h st=%0d last=%0d",
                     r.kind, r.code, r.flags, r.len, r.ida, r.hop, r.endi, r.st, r.last);
  endfunction

  // --------------------------------------------------------------------------
  // clock, and every input known from time zero
  // --------------------------------------------------------------------------
  initial begin
    clk                 = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_buffer = 1'b0;
    out_ch.ready        = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // byte driver: changes on the falling edge, holds an item until taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : byte_driver
    plan_item_t  it;
    logic        v, e;
    logic [7:0]  d;
    bit          calm;
    calm = (byte_plan.size() < CALM_BYTES);
    v    = 1'b0;
    d    = $urandom;
    e    = 1'b0;
    if (!rst_n) begin
      d = '0;
    end else if (in_ch.valid && !in_fire) begin
      // not taken yet, keep it steady
      v = 1'b1;
      d = in_ch.data_byte;
      e = in_ch.end_of_buffer;
    end else if (src_gap > 0 && !calm) begin
      src_gap--;
    end else if (byte_plan.size() > 0 &&
                 !(byte_plan[0].hold && want_records.size() != 0)) begin
      if (!calm && src_quiet == 0 && $urandom_range(0, 9) == 0) begin
        // start a random idle burst that includes this cycle
        src_gap = $urandom_range(1, 15) - 1;
      end else begin
        if (src_quiet > 0) src_quiet--;
        else if ($urandom_range(0, 24) == 0) src_quiet = $urandom_range(20, 120);
        it = byte_plan.pop_front();
        v  = 1'b1;
        d  = it.data;
        e  = it.eob;
      end
    end
    in_ch.valid         <= v;
    in_ch.data_byte     <= d;
    in_ch.end_of_buffer <= e;
  end

  // --------------------------------------------------------------------------
  // record sink: random back-pressure in bursts, quiet stretches in between
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : record_sink
    logic rdy;
    bit   calm;
    calm = (byte_plan.size() < CALM_BYTES);
    rdy  = 1'b1;
    if (!rst_n) begin
      rdy = 1'b0;
    end else if (calm) begin
      snk_gap = 0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      rdy = 1'b0;
    end else if (snk_quiet > 0) begin
      snk_quiet--;
    end else begin
      case ($urandom_range(0, 15))
        0, 1: begin
          snk_gap = $urandom_range(1, 15) - 1;
          rdy     = 1'b0;
        end
        2: snk_quiet = $urandom_range(20, 120);
        default: ;
      endcase
    end
    out_ch.ready <= rdy;
  end

  // --------------------------------------------------------------------------
  // monitor: sample both handshakes on the rising edge; check records leaving
  // the block, then predict from the byte taken at the same edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    rec_t got, want;
    bit   any_fire;
    in_fire  = 1'b0;
    any_fire = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        any_fire   = 1'b1;
        got.kind   = kind_t'(out_ch.record_kind);
        got.code   = out_ch.code;
        got.flags  = out_ch.flag_bits;
        got.len    = out_ch.length_value;
        got.ida    = out_ch.ident_a;
        got.hop    = out_ch.hop_ident;
        got.endi   = out_ch.end_ident;
        got.st     = status_t'(out_ch.status);
        got.last   = out_ch.last;
        if (want_records.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("[%0t] record with nothing pending: %s", $time, rec_text(got));
          end
        end else begin
          want = want_records.pop_front();
          if (got.kind !== want.kind || got.code !== want.code ||
              got.flags !== want.flags || got.len !== want.len ||
              got.ida !== want.ida || got.hop !== want.hop ||
              got.endi !== want.endi || got.st !== want.st ||
              got.last !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("[%0t] record mismatch", $time);
              $display("  expected %s", rec_text(want));
              $display("  actual   %s", rec_text(got));
            end
          end
          case (want.kind)
            KIND_HDR: n_hdr++;
            KIND_AVP: n_avp++;
            default: begin
              n_stat++;
              status_seen[want.st]++;
            end
          endcase
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_fire  = 1'b1;
        any_fire = 1'b1;
        bytes_taken++;
        if (in_ch.end_of_buffer) n_buffers++;
        frame_byte(in_ch.data_byte, in_ch.end_of_buffer);
      end
      if (any_fire) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // watchdog: no handshake on either side for too long
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
    $display("tb_diameter_header_avp_framer_top: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // plan, reset and end of run
  // --------------------------------------------------------------------------
  initial begin : main
    int unsigned target, keep, n_avp_rand, dlen, i;
    logic [7:0]  fl;
    rst_n = 1'b0;
    reset_model();
    status_seen = '{default: 0};

    // ---- directed buffers ----
    // lone byte, then 19 bytes of ones: both too short for a header
    add_byte(8'h00);
    send_msg(1'b0);
    repeat (19) add_byte(8'hFF);
    send_msg(1'b0);
    // header only, every field at its top value
    put_header(8'h01, 8'hFF, 24'd20, 24'hFFFFFF, '1, '1, '1);
    send_msg(1'b0);
    // header only, every field zero; sender waits for the block to drain first
    put_header(8'h01, 8'h00, 24'd20, 24'h0, '0, '0, '0);
    send_msg(1'b1);
    // bad version, high and zero
    put_header(8'hFF, 8'h80, 24'd20, $urandom, $urandom, $urandom, $urandom);
    send_msg(1'b0);
    put_header(8'h00, 8'h00, 24'd20, $urandom, $urandom, $urandom, $urandom);
    send_msg(1'b0);
    // message length just below the header size
    put_header(8'h01, $urandom, 24'd19, $urandom, $urandom, $urandom, $urandom);
    send_msg(1'b0);
    // largest message length, buffer ends after the header: incomplete
    put_header(8'h01, $urandom, 24'hFFFFFF, $urandom, $urandom, $urandom, $urandom);
    send_msg(1'b0);
    // short buffer outranks a bad version
    put_header(8'h00, 8'h00, 24'd40, 24'h0, '0, '0, '0);
    repeat (10) void'(msg_bytes.pop_back());
    send_msg(1'b0);
    // bad version outranks incomplete
    put_header(8'h02, 8'h00, 24'd100, $urandom, $urandom, $urandom, $urandom);
    send_msg(1'b0);
    // plain avp with an all-ones code, vendor avp with an all-ones vendor id, odd lengths with padding
    put_header(8'h01, 8'h80, 24'd0, $urandom, $urandom, $urandom, $urandom);
    put_avp(32'hFFFFFFFF, 8'h40, 24'd8, 32'h0, 0, 1'b1);
    put_avp(32'h0, 8'hFF, 24'd12, 32'hFFFFFFFF, 0, 1'b1);
    put_avp($urandom, 8'h00, 24'd13, 32'h0, 5, 1'b1);
    put_avp($urandom, 8'h80, 24'd17, $urandom, 5, 1'b1);
    fix_len();
    send_msg(1'b0);
    // avp length below 8
    put_header(8'h01, $urandom, 24'd0, $urandom, $urandom, $urandom, $urandom);
    put_avp($urandom, 8'h00, 24'd7, 32'h0, 4, 1'b1);
    fix_len();
    send_msg(1'b0);
    // vendor avp with length below 12
    put_header(8'h01, $urandom, 24'd0, $urandom, $urandom, $urandom, $urandom);
    put_avp($urandom, 8'h80, 24'd11, $urandom, 0, 1'b1);
    fix_len();
    send_msg(1'b0);
    // avp data would run past the message
    put_header(8'h01, $urandom, 24'd0, $urandom, $urandom, $urandom, $urandom);
    put_avp($urandom, 8'h00, 24'hFFFFFF, 32'h0, 4, 1'b1);
    fix_len();
    send_msg(1'b0);
    // avp header cut by the message length
    put_header(8'h01, $urandom, 24'd25, $urandom, $urandom, $urandom, $urandom);
    repeat (5) add_byte($urandom);
    send_msg(1'b0);
    // good avp then a 3-byte fragment before the end
    put_header(8'h01, $urandom, 24'd0, $urandom, $urandom, $urandom, $urandom);
    put_avp($urandom, 8'h00, 24'd8, 32'h0, 0, 1'b1);
    repeat (3) add_byte($urandom);
    fix_len();
    send_msg(1'b0);
    // vendor flag but the vendor id would pass the message length
    put_header(8'h01, $urandom, 24'd0, $urandom, $urandom, $urandom, $urandom);
    put_avp($urandom, 8'hC0, 24'd12, $urandom, 0, 1'b1);
    set_len(24'd28);
    send_msg(1'b0);
    // last avp unpadded, padding carries past the end: no error
    put_header(8'h01, $urandom, 24'd0, $urandom, $urandom, $urandom, $urandom);
    put_avp($urandom, 8'h00, 24'd9, 32'h0, 1, 1'b0);
    fix_len();
    send_msg(1'b0);
    // trailing bytes past the message length are ignored
    put_header(8'h01, $urandom, 24'd0, $urandom, $urandom, $urandom, $urandom);
    put_avp($urandom, 8'h80, 24'd16, $urandom, 4, 1'b1);
    fix_len();
    repeat (6) add_byte($urandom);
    send_msg(1'b0);
    // first avp error sticks, later ones do not show
    put_header(8'h01, $urandom, 24'd0, $urandom, $urandom, $urandom, $urandom);
    put_avp($urandom, 8'h00, 24'd4, 32'h0, 0, 1'b1);
    put_avp($urandom, 8'h00, 24'hFFFFFF, 32'h0, 0, 1'b1);
    fix_len();
    send_msg(1'b0);
    // avp error but buffer short of the message: incomplete wins
    put_header(8'h01, $urandom, 24'd0, $urandom, $urandom, $urandom, $urandom);
    put_avp($urandom, 8'h00, 24'd5, 32'h0, 0, 1'b1);
    set_len(msg_bytes.size() + 20);
    send_msg(1'b0);

    // ---- random buffers ----
    target = byte_plan.size() + RANDOM_BYTES;
    while (byte_plan.size() < target) begin
      if ($urandom_range(0, 7) == 0) begin
        // noise, sometimes with a valid version byte
        repeat ($urandom_range(1, 40)) add_byte($urandom);
        if ($urandom_range(0, 1) == 1) msg_bytes[0] = DIAM_VERSION;
      end else begin
        put_header(DIAM_VERSION, $urandom, 24'd0, $urandom, $urandom, $urandom, $urandom);
        n_avp_rand = $urandom_range(0, 4);
        for (i = 0; i < n_avp_rand; i++) begin
          fl   = $urandom;
          dlen = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 250) : $urandom_range(0, 10);
          put_avp($urandom, fl, (fl[7] ? AVP_HDR_VEND : AVP_HDR_BASE) + dlen, $urandom, dlen,
                  !(i == n_avp_rand - 1 && $urandom_range(0, 3) == 0));
        end
        fix_len();
        // pick one of nine ways to break or alter the message, or none
        case ($urandom_range(0, 13))
          0: begin
            fl = $urandom;
            if (fl == DIAM_VERSION) fl = 8'h00;
            msg_bytes[0] = fl;
          end
          1: set_len($urandom_range(0, HDR_BYTES - 1));
          2: set_len(msg_bytes.size() + $urandom_range(1, 40));
          3: if (msg_bytes.size() > HDR_BYTES) begin
            set_len(msg_bytes.size() - $urandom_range(1, 12));
          end
          4: begin
            keep = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
          end
          5: repeat ($urandom_range(1, 8)) add_byte($urandom);
          6: if (msg_bytes.size() >= HDR_BYTES + AVP_HDR_BASE) begin
            msg_bytes[25] = 8'h00;
            msg_bytes[26] = 8'h00;
            msg_bytes[27] = $urandom_range(0, 15);
          end
          7: if (msg_bytes.size() > HDR_BYTES) begin
            msg_bytes[$urandom_range(HDR_BYTES, msg_bytes.size() - 1)] = $urandom;
          end
          8: if (msg_bytes.size() >= HDR_BYTES + AVP_HDR_BASE) begin
            msg_bytes[24] = msg_bytes[24] ^ 8'h80;
          end
          default: ;
        endcase
      end
      send_msg($urandom_range(0, 29) == 0);
    end
    total_bytes = byte_plan.size();

    // synchronous reset, released away from the sampling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (bytes_taken < total_bytes) @(posedge clk);
    while (want_records.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    errors += want_records.size();

    $display("run: %0d bytes in %0d buffers, %0d header + %0d avp + %0d status records checked",
             bytes_taken, n_buffers, n_hdr, n_avp, n_stat);
    $display("status mix: ok %0d short %0d ver %0d len %0d incompl %0d trunc %0d small %0d over %0d",
             status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_VERSION],
             status_seen[ST_MSGLEN], status_seen[ST_INCOMPLETE], status_seen[ST_AVP_TRUNC],
             status_seen[ST_AVP_SMALL], status_seen[ST_AVP_OVERRUN]);
    if (errors == 0) begin
      $display("tb_diameter_header_avp_framer_top: PASS");
    end else begin
      $display("%0d failures", errors);
      $display("tb_diameter_header_avp_framer_top: FAIL");
    end
    $finish;
  end

endmodule
